[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL files of the decoder.
// Each macro expands to one labeled concurrent assertion clocked by clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk while rst_n is high.
`define CHK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge of clk, during reset as well.
`define CHK_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/b64u_pkg.sv]
// Types, constants and the character map of the base64url decoder.
// No dependencies.
`timescale 1ns / 1ps

package b64u_pkg;

    localparam int unsigned SYM_W     = 6;
    localparam int unsigned BYTE_W    = 8;
    localparam logic [SYM_W-1:0] SYM_MAX = SYM_W'(63);
    localparam logic [SYM_W-1:0] SYM_DASH = SYM_W'(62);

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2,
        PH_FOURTH = 2'd3
    } phase_t;

    typedef struct packed {
        phase_t           phase;
        logic [SYM_W-1:0] held;
        logic             failed;
    } dec_state_t;

    typedef struct packed {
        logic              has_result;
        logic [BYTE_W-1:0] data;
        logic              data_valid;
        logic              bad;
        logic              last;
    } dec_result_t;

    typedef struct packed {
        logic             ok;
        logic [SYM_W-1:0] sym;
    } sym_lookup_t;

    localparam dec_state_t STATE_CLEAR = '{phase: PH_FIRST, held: '0, failed: 1'b0};

    // Maps one character byte to its 6-bit symbol; ok is low for any other byte.
    function automatic sym_lookup_t map_char(input logic [BYTE_W-1:0] c);
        sym_lookup_t r;
        r.ok  = 1'b1;
        r.sym = '0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r.sym = SYM_W'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r.sym = SYM_W'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r.sym = SYM_W'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2D || c == 8'h2B) begin
            r.sym = SYM_DASH;
        end else if (c == 8'h5F || c == 8'h2F) begin
            r.sym = SYM_MAX;
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

[hw/rtl/b64u_step.sv]
// One decode step: maps a character and combines it with the group state.
// Depends on b64u_pkg.
`timescale 1ns / 1ps

module b64u_step
    import b64u_pkg::*;
(
    input  logic [BYTE_W-1:0] char_in,
    input  logic              end_of_text,
    input  dec_state_t        state_cur,
    output dec_state_t        state_next,
    output dec_result_t       result
);

    sym_lookup_t lookup;

    assign lookup = map_char(char_in);

    always_comb
    begin
        state_next        = state_cur;
        result.has_result = 1'b0;
        result.data       = '0;
        result.data_valid = 1'b0;
        result.bad        = 1'b0;
        result.last       = end_of_text;

        if (state_cur.failed) begin
            // Everything up to the final character of a failed string is dropped.
            if (end_of_text) begin
                result.has_result = 1'b1;
                result.bad        = 1'b1;
                state_next        = STATE_CLEAR;
            end
        end else if (!lookup.ok) begin
            result.has_result = 1'b1;
            result.bad        = 1'b1;
            if (end_of_text) begin
                state_next = STATE_CLEAR;
            end else begin
                state_next.failed = 1'b1;
            end
        end else begin
            case (state_cur.phase)
                PH_FIRST:
                begin
                    if (end_of_text) begin
                        // A lone trailing character cannot form a byte.
                        result.has_result = 1'b1;
                        result.bad        = 1'b1;
                    end
                    state_next.phase = PH_SECOND;
                end
                PH_SECOND:
                begin
                    result.has_result = 1'b1;
                    result.data_valid = 1'b1;
                    result.data       = {state_cur.held, lookup.sym[5:4]};
                    state_next.phase  = PH_THIRD;
                end
                PH_THIRD:
                begin
                    result.has_result = 1'b1;
                    result.data_valid = 1'b1;
                    result.data       = {state_cur.held[3:0], lookup.sym[5:2]};
                    state_next.phase  = PH_FOURTH;
                end
                PH_FOURTH:
                begin
                    result.has_result = 1'b1;
                    result.data_valid = 1'b1;
                    result.data       = {state_cur.held[1:0], lookup.sym};
                    state_next.phase  = PH_FIRST;
                end
                default:
                begin
                    state_next.phase = PH_FIRST;
                end
            endcase
            state_next.held = lookup.sym;
            if (end_of_text) begin
                state_next = STATE_CLEAR;
            end
        end
    end

endmodule

[hw/rtl/base64url_decoder.sv]
// Top level of the unpadded base64url decoder: input register, decode step, result register.
// Depends on b64u_pkg, b64u_step and assert_macros.svh.
`timescale 1ns / 1ps

// The decoder takes one character item per clock and returns one result item on the
// second, third and fourth character of each four-character group, plus an error item
// for an invalid character, a lone trailing character or the end of a failed string.
// An accepted item is held in the input register and is decoded into the result register
// at the next edge at which the result register is free.
// While results are taken, a new item is accepted every cycle. When a result waits, the
// input register holds one more item and then the input stalls.
// Both '-' and '+' decode to 62 and both '_' and '/' to 63. After the item flagged by
// end_of_text the group state is cleared for the next string.

module base64url_decoder
    import b64u_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] char_in,
    input  logic              end_of_text,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] byte_out,
    output logic              byte_valid,
    output logic              bad_input,
    output logic              stream_end
);

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [BYTE_W-1:0] s1_char_reg;
    logic              s1_eot_reg;
    dec_state_t        state_reg;
    dec_state_t        state_next;
    dec_result_t       step_result;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              byte_valid_reg;
    logic              bad_reg;
    logic              end_reg;
    logic              out_free;
    logic              s1_consume;
    logic              in_accept;

    b64u_step u_step (
        .char_in     (s1_char_reg),
        .end_of_text (s1_eot_reg),
        .state_cur   (state_reg),
        .state_next  (state_next),
        .result      (step_result)
    );

    assign out_free   = !out_valid_reg || out_ready;
    assign s1_consume = s1_valid_reg && out_free;
    assign in_ready   = !s1_valid_reg || s1_consume;
    assign in_accept  = in_valid && in_ready;

    assign s1_valid_next  = in_accept || (s1_valid_reg && !s1_consume);
    assign out_valid_next = s1_consume ? step_result.has_result
                                       : (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_CLEAR;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_consume) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept) begin
            s1_char_reg <= char_in;
            s1_eot_reg  <= end_of_text;
        end
        if (s1_consume && step_result.has_result) begin
            byte_reg       <= step_result.data;
            byte_valid_reg <= step_result.data_valid;
            bad_reg        <= step_result.bad;
            end_reg        <= step_result.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign byte_out   = byte_reg;
    assign byte_valid = byte_valid_reg;
    assign bad_input  = bad_reg;
    assign stream_end = end_reg;

`include "assert_macros.svh"

    `CHK_ASSERT(a_byte_or_error,
        out_valid_reg |-> !(byte_valid_reg && bad_reg),
        "byte and error flags both set")
    `CHK_ASSERT(a_zero_on_error,
        (out_valid_reg && !byte_valid_reg) |-> (byte_reg == '0),
        "byte not zero on error item")
    `CHK_ASSERT(a_clear_after_end,
        (s1_consume && s1_eot_reg) |=> (state_reg == STATE_CLEAR),
        "state not cleared after final item")
    `CHK_ASSERT(a_failed_drops,
        (s1_consume && state_reg.failed && !s1_eot_reg) |=> !out_valid_reg,
        "failed string produced an item")

endmodule
